FILE: hdl/assert_macros.svh
// Assertion macros shared by the checker files.
// Depends on nothing; included by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define BBA_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// Implication checked in the cycle after the antecedent.
`define BBA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

FILE: hdl/bba_pkg.sv
// Package for the buddy block allocator: constants, codes, state type, command structs.
// Depends on nothing.
package bba_pkg;
  localparam int ORDER_LIMIT = 10;
  localparam int UNIT_BYTES  = 4096;
  localparam int UNIT_SHIFT  = $clog2(UNIT_BYTES);
  localparam int OW          = $clog2(ORDER_LIMIT + 2);
  localparam int IW          = ORDER_LIMIT + 1;          // id width incl. count ORDER_LIMIT
  localparam int SLOTS       = 2 << ORDER_LIMIT;
  localparam int SW          = $clog2(SLOTS);

  localparam logic [1:0] KIND_ALLOC = 2'd0;
  localparam logic [1:0] KIND_FREE  = 2'd1;
  localparam logic [1:0] KIND_INIT  = 2'd2;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NOBLOCK = 2'd1;
  localparam logic [1:0] ST_ORDER   = 2'd2;
  localparam logic [1:0] ST_NOINIT  = 2'd3;

  localparam logic [1:0] REG_MAX_ORDER = 2'd0;
  localparam logic [1:0] REG_RESERVED  = 2'd1;
  localparam logic [1:0] REG_BASE      = 2'd2;

  typedef enum logic [3:0] {
    S_IDLE, S_CLEAR, S_INIT, S_SCAN, S_SCAN_RD, S_SPLIT,
    S_FREE_RD, S_FREE_CHK, S_FREE_SET, S_DONE
  } bba_state_t;

  // datapath operations requested by the controller
  typedef enum logic [3:0] {
    OP_NONE, OP_LOAD, OP_CLR_START, OP_CLR_STEP, OP_INIT_STEP, OP_SCAN_RD,
    OP_SCAN_NEXT, OP_SCAN_TAKE, OP_SPLIT, OP_FREE_RD, OP_FREE_MERGE, OP_FREE_SET,
    OP_RESULT
  } bba_op_t;

  typedef struct packed {
    bba_op_t    op;
    logic [1:0] status;
    logic       ok_addr;
  } bba_cmd_t;

  typedef struct packed {
    logic clr_done;
    logic init_done;
    logic rd_bit;
    logic scan_last_id;
    logic scan_last_order;
    logic split_done;
    logic free_out;
    logic merge_top;
    logic ready;
    logic order_bad;
  } bba_stat_t;

  function automatic logic [SW-1:0] slot_of(input logic [OW-1:0] k, input logic [IW-1:0] id);
    logic [SW:0] s;
    s = (SW+1)'(1) << (ORDER_LIMIT - int'(k));
    return SW'(s + (SW+1)'(id));
  endfunction
endpackage

FILE: hdl/bba_ctrl.sv
// Controller state machine of the buddy block allocator.
// Depends on bba_pkg; drives commands to bba_dp and reads its status.
module bba_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [1:0]         kind,
  input  logic               out_free,
  input  bba_pkg::bba_stat_t st,
  output bba_pkg::bba_cmd_t  cmd,
  output logic               busy
);
  import bba_pkg::*;
  bba_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          if (kind == KIND_INIT) state_nxt = S_CLEAR;
          else if (kind == KIND_ALLOC || kind == KIND_FREE) begin
            if (!st.ready || st.order_bad) state_nxt = S_DONE;
            else if (kind == KIND_ALLOC)   state_nxt = S_SCAN_RD;
            else                           state_nxt = S_FREE_RD;
          end else state_nxt = S_DONE;
        end
      end
      S_CLEAR:    if (st.clr_done) state_nxt = S_INIT;
      S_INIT:     if (st.init_done) state_nxt = S_DONE;
      S_SCAN_RD:  state_nxt = S_SCAN;
      S_SCAN: begin
        if (st.rd_bit) state_nxt = S_SPLIT;
        else if (st.scan_last_id && st.scan_last_order) state_nxt = S_DONE;
        else state_nxt = S_SCAN_RD;
      end
      S_SPLIT:    if (st.split_done) state_nxt = S_DONE;
      S_FREE_RD:  state_nxt = st.free_out ? S_DONE : S_FREE_CHK;
      S_FREE_CHK: state_nxt = (st.rd_bit && !st.merge_top) ? S_FREE_RD : S_FREE_SET;
      S_FREE_SET: state_nxt = S_DONE;
      S_DONE:     if (out_free) state_nxt = S_IDLE;
      default:    state_nxt = S_IDLE;
    endcase
  end

  // status code latched with the result; kept in datapath
  always_comb begin
    cmd = '{op: OP_NONE, status: ST_OK, ok_addr: 1'b0};
    case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.op = OP_LOAD;
          if (kind == KIND_INIT) cmd.op = OP_CLR_START;
          else if (kind == KIND_ALLOC || kind == KIND_FREE) begin
            if (!st.ready)         begin cmd.op = OP_RESULT; cmd.status = ST_NOINIT; end
            else if (st.order_bad) begin cmd.op = OP_RESULT; cmd.status = ST_ORDER; end
          end else begin cmd.op = OP_RESULT; end
        end
      end
      S_CLEAR: cmd.op = OP_CLR_STEP;
      S_INIT: begin
        cmd.op = st.init_done ? OP_RESULT : OP_INIT_STEP;
      end
      S_SCAN_RD: cmd.op = OP_SCAN_RD;
      S_SCAN: begin
        if (st.rd_bit) cmd.op = OP_SCAN_TAKE;
        else if (st.scan_last_id && st.scan_last_order) begin
          cmd.op = OP_RESULT; cmd.status = ST_NOBLOCK;
        end else cmd.op = OP_SCAN_NEXT;
      end
      S_SPLIT: begin
        if (st.split_done) begin cmd.op = OP_RESULT; cmd.ok_addr = 1'b1; end
        else cmd.op = OP_SPLIT;
      end
      S_FREE_RD: begin
        if (st.free_out) begin cmd.op = OP_RESULT; cmd.status = ST_NOBLOCK; end
        else cmd.op = OP_FREE_RD;
      end
      S_FREE_CHK: cmd.op = (st.rd_bit && !st.merge_top) ? OP_FREE_MERGE : OP_FREE_SET;
      S_FREE_SET: cmd.op = OP_RESULT;
      default: cmd.op = OP_NONE;
    endcase
  end

  assign busy = (state_r != S_IDLE);
endmodule

FILE: hdl/bba_dp.sv
// Datapath of the buddy block allocator: free map memory, config latches, walkers.
// Depends on bba_pkg; driven by bba_ctrl commands.
module bba_dp (
  input  logic               clk,
  input  logic               rst_n,
  input  bba_pkg::bba_cmd_t  cmd,
  input  logic [1:0]         in_kind,
  input  logic [3:0]         in_order,
  input  logic [31:0]        in_addr,
  input  logic [3:0]         reg_max_order,
  input  logic [9:0]         reg_reserved,
  input  logic [31:0]        reg_base,
  input  logic               out_take,
  output bba_pkg::bba_stat_t st,
  output logic               out_valid,
  output logic [1:0]         out_status,
  output logic [31:0]        out_addr
);
  import bba_pkg::*;

  logic              fmap [SLOTS];
  logic              rd_r;
  logic [SW-1:0]     rd_a, wr_a;
  logic              wr_en, wr_d;

  logic              ready_r, ready_nxt;
  logic [OW-1:0]     m_r, m_nxt;
  logic [31:0]       base_r, base_nxt;
  logic [OW-1:0]     req_r, req_nxt;       // requested order
  logic [OW-1:0]     k_r, k_nxt;           // current order
  logic [IW-1:0]     id_r, id_nxt;
  logic [IW:0]       left_r, left_nxt;
  logic [IW:0]       pos_r, pos_nxt;
  logic [SW:0]       clr_r, clr_nxt;
  logic              far_r, far_nxt;       // freed address lies outside the pool
  logic              ov_r, ov_nxt;
  logic [1:0]        os_r, os_nxt;
  logic [31:0]       oa_r, oa_nxt;

  logic [OW-1:0]     m_cfg;
  logic [IW:0]       pool_cfg, pool_cur;
  logic [31:0]       off, unit;
  logic [IW-1:0]     cnt_m1;

  always_ff @(posedge clk) begin
    if (wr_en) fmap[wr_a] <= wr_d;
    rd_r <= fmap[rd_a];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ready_r <= 1'b0; m_r <= '0; base_r <= '0; ov_r <= 1'b0;
    end else begin
      ready_r <= ready_nxt; m_r <= m_nxt; base_r <= base_nxt; ov_r <= ov_nxt;
    end
    req_r <= req_nxt; k_r <= k_nxt; id_r <= id_nxt; left_r <= left_nxt;
    pos_r <= pos_nxt; clr_r <= clr_nxt; os_r <= os_nxt; oa_r <= oa_nxt;
    far_r <= far_nxt;
  end

  assign m_cfg    = (reg_max_order > 4'(ORDER_LIMIT)) ? OW'(ORDER_LIMIT) : OW'(reg_max_order);
  assign pool_cfg = (IW+1)'(1) << m_cfg;
  assign pool_cur = (IW+1)'(1) << m_r;
  assign cnt_m1   = IW'((pool_cur >> k_r) - (IW+1)'(1));
  assign off      = in_addr - base_r;
  assign unit     = off >> UNIT_SHIFT;

  always_comb begin
    st = '0;
    st.ready           = ready_r;
    st.order_bad       = ({1'b0, in_order} > (OW+1)'(m_r));
    st.clr_done        = (clr_r == (SW+1)'(SLOTS - 1));
    st.init_done       = (left_r == '0);
    st.rd_bit          = rd_r;
    st.scan_last_id    = (id_r == cnt_m1);
    st.scan_last_order = (k_r == m_r);
    st.split_done      = (k_r == req_r);
    st.free_out        = (k_r == req_r) && far_r;
    st.merge_top       = (k_r == m_r);
  end

  always_comb begin
    ready_nxt = ready_r; m_nxt = m_r; base_nxt = base_r;
    req_nxt = req_r; k_nxt = k_r; id_nxt = id_r; left_nxt = left_r;
    pos_nxt = pos_r; clr_nxt = clr_r; ov_nxt = ov_r; os_nxt = os_r; oa_nxt = oa_r;
    far_nxt = far_r;
    rd_a = slot_of(k_r, id_r); wr_a = slot_of(k_r, id_r); wr_en = 1'b0; wr_d = 1'b0;
    if (out_take) ov_nxt = 1'b0;
    case (cmd.op)
      OP_LOAD: begin
        req_nxt = OW'(in_order); k_nxt = OW'(in_order); id_nxt = '0;
        far_nxt = (in_kind == KIND_FREE) && (unit >= 32'(pool_cur));
        if (in_kind == KIND_FREE) id_nxt = IW'(unit >> in_order);
      end
      OP_CLR_START: begin
        clr_nxt = '0; m_nxt = m_cfg; base_nxt = reg_base; ready_nxt = 1'b1;
        left_nxt = ((IW+1)'(reg_reserved) >= pool_cfg) ? '0
                   : pool_cfg - (IW+1)'(reg_reserved);
        pos_nxt = '0;
      end
      OP_CLR_STEP: begin
        wr_en = 1'b1; wr_a = SW'(clr_r); wr_d = 1'b0; clr_nxt = clr_r + 1'b1;
      end
      OP_INIT_STEP: begin
        // take the highest set bit of what is left, one block per cycle
        for (int b = 0; b <= IW; b++) begin
          if (left_r[b]) k_nxt = OW'(b);
        end
        wr_en = 1'b1; wr_d = 1'b1;
        wr_a = slot_of(k_nxt, IW'(pos_r >> k_nxt));
        pos_nxt  = pos_r + ((IW+1)'(1) << k_nxt);
        left_nxt = left_r & ~((IW+1)'(1) << k_nxt);
      end
      OP_SCAN_RD: rd_a = slot_of(k_r, id_r);
      OP_SCAN_NEXT: begin
        if (id_r == cnt_m1) begin id_nxt = '0; k_nxt = k_r + 1'b1; end
        else id_nxt = id_r + 1'b1;
      end
      OP_SCAN_TAKE: begin
        wr_en = 1'b1; wr_d = 1'b0;
      end
      OP_SPLIT: begin
        wr_en = 1'b1; wr_d = 1'b1;
        wr_a = slot_of(k_r - 1'b1, IW'({id_r, 1'b1}));
        id_nxt = IW'({id_r, 1'b0}); k_nxt = k_r - 1'b1;
      end
      OP_FREE_RD: begin
        if (k_r == m_r) begin
          // no buddy at the top: CHK sees rd_bit from top slot; force set
          rd_a = slot_of(k_r, id_r);
        end else rd_a = slot_of(k_r, id_r ^ IW'(1));
        req_nxt = OW'(ORDER_LIMIT + 1);
      end
      OP_FREE_MERGE: begin
        wr_en = 1'b1; wr_d = 1'b0; wr_a = slot_of(k_r, id_r ^ IW'(1));
        id_nxt = id_r >> 1; k_nxt = k_r + 1'b1;
      end
      OP_FREE_SET: begin
        wr_en = 1'b1; wr_d = 1'b1;
      end
      OP_RESULT: begin
        ov_nxt = 1'b1; os_nxt = cmd.status;
        oa_nxt = cmd.ok_addr
               ? base_r + (32'(id_r) << (32'(req_r) + UNIT_SHIFT)) : 32'd0;
      end
      default: ;
    endcase
  end

  assign out_valid  = ov_r;
  assign out_status = os_r;
  assign out_addr   = oa_r;
endmodule

FILE: hdl/bba_cfg.sv
// APB register file of the buddy block allocator.
// Depends on bba_pkg for register indexes.
module bba_cfg (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic [3:0]  max_order,
  output logic [9:0]  reserved,
  output logic [31:0] base
);
  import bba_pkg::*;
  logic [3:0]  mo_r;
  logic [9:0]  rs_r;
  logic [31:0] bs_r;
  logic        we;
  assign we = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mo_r <= 4'd10; rs_r <= '0; bs_r <= '0;
    end else if (we) begin
      case (paddr[3:2])
        REG_MAX_ORDER: mo_r <= pwdata[3:0];
        REG_RESERVED:  rs_r <= pwdata[9:0];
        REG_BASE:      bs_r <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_MAX_ORDER: prdata = {28'd0, mo_r};
      REG_RESERVED:  prdata = {22'd0, rs_r};
      REG_BASE:      prdata = bs_r;
      default:       prdata = '0;
    endcase
  end
  assign max_order = mo_r;
  assign reserved  = rs_r;
  assign base      = bs_r;
endmodule

FILE: hdl/buddy_block_allocator_top.sv
// Top level of the buddy block allocator: APB registers, controller, datapath.
// Depends on bba_pkg, bba_cfg, bba_ctrl and bba_dp.
//
// Use: configure max_order, reserved_units and base_address over the APB
// port (addresses 0, 4, 8), then send an init transfer (kind 2) on in_*.
// Allocate (kind 0) and free (kind 1) transfers follow; each produces one
// result transfer on out_* with status and address.
// One item at a time: in_tready is high only while the engine is idle.
// Steps: allocate scans the free-map bits order by order and then splits
// down level by level; free merges level by level; init clears the whole
// free-map memory of 2^(ORDER_LIMIT+1) slots and then writes one free
// block per step. The free-map memory has one write and one read port.
// The result sits in an output register; the engine holds in its done
// state until that result is taken and accepts the next item from the
// cycle after. While the receiver stalls, the finished engine holds in its
// done state.
// Reset clears the pool-ready flag; allocate and free before init report
// status 3.
module buddy_block_allocator_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // block_order[3:0], block_address[35:4], zero pad
  input  logic [1:0]  in_tuser,   // kind[1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // status[1:0], result_address[33:2], zero pad
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import bba_pkg::*;
  bba_cmd_t    cmd;
  bba_stat_t   st;
  logic        busy, ov, take, start;
  logic [1:0]  os;
  logic [31:0] oa;
  logic [3:0]  r_mo;
  logic [9:0]  r_rs;
  logic [31:0] r_bs;

  assign cfg_pready = 1'b1;
  assign take       = ov && out_tready;
  assign in_tready  = !busy;
  assign start      = in_tvalid && in_tready;

  bba_cfg u_cfg (
    .clk, .rst_n, .psel(cfg_psel), .penable(cfg_penable), .pwrite(cfg_pwrite),
    .paddr(cfg_paddr), .pwdata(cfg_pwdata), .prdata(cfg_prdata),
    .max_order(r_mo), .reserved(r_rs), .base(r_bs)
  );

  // Done state waits until the result in the output register is taken.
  bba_ctrl u_ctrl (
    .clk, .rst_n, .start, .kind(in_tuser), .out_free(!ov || take),
    .st, .cmd, .busy
  );

  bba_dp u_dp (
    .clk, .rst_n, .cmd, .in_kind(in_tuser), .in_order(in_tdata[3:0]),
    .in_addr(in_tdata[35:4]), .reg_max_order(r_mo), .reg_reserved(r_rs),
    .reg_base(r_bs), .out_take(take), .st, .out_valid(ov), .out_status(os),
    .out_addr(oa)
  );

  assign out_tvalid = ov;
  assign out_tdata  = {6'd0, oa, os};
endmodule

FILE: hdl/bba_checker.sv
// Port-level checker for the buddy block allocator, bound to the top level.
// Depends on assert_macros.svh.
`include "assert_macros.svh"
module bba_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [39:0] out_tdata,
  input logic        cfg_pready
);
  `BBA_ASSERT_IMP(a_pready, clk, rst_n, 1'b1, cfg_pready)
  `BBA_ASSERT_NEXT(a_busy, clk, rst_n, in_tvalid && in_tready, !in_tready)
  `BBA_ASSERT_NEXT(a_hold, clk, rst_n, out_tvalid && !out_tready, $stable(out_tdata))
  `BBA_ASSERT_IMP(a_pad, clk, rst_n, out_tvalid, out_tdata[39:34] == 6'd0)
endmodule

bind buddy_block_allocator_top bba_checker u_chk (
  .clk, .rst_n, .in_tvalid, .in_tready, .out_tvalid, .out_tready, .out_tdata,
  .cfg_pready
);

FILE: tb/sv/bba_checker.sv
// Scoreboard for the buddy block allocator: watches config, input and result transfers.
// Keeps its own free map per order and compares every result in order.
// Depends on bba_pkg.
module bba_tb_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [39:0] in_tdata,
  input  logic [1:0]  in_tuser,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [39:0] out_tdata,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic        cfg_pready,
  input  logic [3:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output int          err_count,
  output int          pending,
  output int          results_seen
);
  timeunit 1ns;
  timeprecision 1ps;
  import bba_pkg::*;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] addr;
  } alloc_result_t;

  logic          free_bit [0:SLOTS-1];
  logic          pool_up;
  logic [3:0]    max_order_reg;
  logic [9:0]    reserved_reg;
  logic [31:0]   base_reg;
  int unsigned   pool_m;
  logic [31:0]   pool_base;
  alloc_result_t expected_q[$];

  function automatic int unsigned map_idx(int unsigned k, int unsigned id);
    return (1 << (ORDER_LIMIT - k)) + id;
  endfunction

  function automatic void rebuild_pool();
    int unsigned m, pool, left, pos;
    m = (max_order_reg > ORDER_LIMIT) ? ORDER_LIMIT : max_order_reg;
    pool = 1 << m;
    left = (reserved_reg >= pool) ? 0 : pool - reserved_reg;
    pos = 0;
    foreach (free_bit[i]) free_bit[i] = 1'b0;
    pool_m = m;
    pool_base = base_reg;
    pool_up = 1'b1;
    for (int k = m; k >= 0; k--) begin
      if (left[k]) begin
        free_bit[map_idx(k, pos >> k)] = 1'b1;
        pos += 1 << k;
      end
    end
  endfunction

  // lowest-address block of the smallest usable order, split down to the request
  function automatic alloc_result_t take_block(int unsigned order);
    alloc_result_t r;
    int unsigned id;
    bit found;
    r = '{status: ST_NOBLOCK, addr: 32'd0};
    for (int unsigned j = order; j <= pool_m; j++) begin
      found = 0;
      for (id = 0; id < (1 << (pool_m - j)); id++) begin
        if (free_bit[map_idx(j, id)]) begin
          found = 1;
          break;
        end
      end
      if (!found) continue;
      free_bit[map_idx(j, id)] = 1'b0;
      for (int unsigned k = j; k > order; k--) begin
        free_bit[map_idx(k - 1, id * 2 + 1)] = 1'b1;
        id = id * 2;
      end
      r.status = ST_OK;
      r.addr = pool_base + ((id << order) * UNIT_BYTES);
      return r;
    end
    return r;
  endfunction

  function automatic logic [1:0] release_block(int unsigned order, logic [31:0] addr);
    logic [31:0] unit;
    int unsigned id, k;
    unit = (addr - pool_base) >> UNIT_SHIFT;
    if (unit >= (32'd1 << pool_m)) return ST_NOBLOCK;
    id = unit >> order;
    k = order;
    while (k < pool_m && free_bit[map_idx(k, id ^ 1)]) begin
      free_bit[map_idx(k, id ^ 1)] = 1'b0;
      id = id >> 1;
      k++;
    end
    free_bit[map_idx(k, id)] = 1'b1;
    return ST_OK;
  endfunction

  function automatic alloc_result_t predict_item(logic [1:0] kind, logic [3:0] order,
                                                 logic [31:0] addr);
    alloc_result_t r;
    r = '{status: ST_OK, addr: 32'd0};
    if (kind == KIND_INIT) begin
      rebuild_pool();
    end else if (kind == KIND_ALLOC || kind == KIND_FREE) begin
      if (!pool_up) r.status = ST_NOINIT;
      else if (order > pool_m) r.status = ST_ORDER;
      else if (kind == KIND_ALLOC) r = take_block(order);
      else r.status = release_block(order, addr);
    end
    return r;
  endfunction

  initial begin
    err_count = 0;
    results_seen = 0;
    pool_up = 1'b0;
    max_order_reg = 4'd10;
    reserved_reg = '0;
    base_reg = '0;
    pool_m = 0;
    pool_base = '0;
    foreach (free_bit[i]) free_bit[i] = 1'b0;
  end

  always @(posedge clk) begin
    alloc_result_t exp_r, got;
    if (rst_n) begin
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
        case (cfg_paddr[3:2])
          REG_MAX_ORDER: max_order_reg = cfg_pwdata[3:0];
          REG_RESERVED:  reserved_reg  = cfg_pwdata[9:0];
          REG_BASE:      base_reg      = cfg_pwdata;
          default: ;
        endcase
      end
      if (out_tvalid && out_tready) begin
        got = '{status: out_tdata[1:0], addr: out_tdata[33:2]};
        results_seen++;
        if (expected_q.size() == 0) begin
          err_count++;
          $display("%0t: unexpected result: status %0d addr %h", $realtime,
                   got.status, got.addr);
        end else begin
          exp_r = expected_q.pop_front();
          if (got.status !== exp_r.status) begin
            err_count++;
            $display("%0t: status mismatch: expected %0d actual %0d", $realtime,
                     exp_r.status, got.status);
          end
          if (got.addr !== exp_r.addr) begin
            err_count++;
            $display("%0t: address mismatch: expected %h actual %h", $realtime,
                     exp_r.addr, got.addr);
          end
        end
      end
      if (in_tvalid && in_tready)
        expected_q.push_back(predict_item(in_tuser, in_tdata[3:0], in_tdata[35:4]));
    end
    pending = expected_q.size();
  end
endmodule

FILE: tb/sv/buddy_block_allocator_top_test.sv
// Stimulus and verdict for the buddy block allocator.
// Depends on bba_pkg, bba_tb_checker and buddy_block_allocator_top.
module buddy_block_allocator_top_test;
  timeunit 1ns;
  timeprecision 1ps;
  import bba_pkg::*;

  localparam logic [1:0] KIND_NOP = 2'd3;

  typedef struct {
    logic [31:0] addr;
    logic [3:0]  order;
  } live_block_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [39:0] in_tdata;   // block_order[3:0], block_address[35:4], zero pad
  logic [1:0]  in_tuser;   // kind[1:0]
  logic        out_tvalid;
  logic        out_tready;
  logic [39:0] out_tdata;  // status[1:0], result_address[33:2], zero pad
  logic        cfg_psel, cfg_penable, cfg_pwrite;
  logic [3:0]  cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  int err_count, pending, results_seen;
  int items_sent;
  int tx_idle_pct, rx_idle_pct;
  int hold_left;
  bit held_once;
  int unsigned cur_order;
  logic [31:0] cur_base;

  live_block_t live_q[$];   // blocks handed out and not yet released
  logic [1:0]  kind_q[$];   // kinds of accepted items awaiting their result
  logic [3:0]  order_q[$];  // orders of the same items

  buddy_block_allocator_top i_dut (.*);

  bba_tb_checker i_checker (
    .clk, .rst_n, .in_tvalid, .in_tready, .in_tdata, .in_tuser,
    .out_tvalid, .out_tready, .out_tdata,
    .cfg_psel, .cfg_penable, .cfg_pwrite, .cfg_pready, .cfg_paddr, .cfg_pwdata,
    .err_count, .pending, .results_seen
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Receiver: random stalls, plus one long hold-off early on so the block backs up.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      hold_left <= 0;
      held_once <= 1'b0;
    end else if (!held_once && items_sent == 120) begin
      held_once <= 1'b1;
      hold_left <= 400;
      out_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // Track successful allocations so frees can return real blocks.
  always @(posedge clk) begin
    logic [1:0] k;
    logic [3:0] o;
    if (rst_n && out_tvalid && out_tready && kind_q.size() > 0) begin
      k = kind_q.pop_front();
      o = order_q.pop_front();
      if (k == KIND_INIT) live_q.delete();
      else if (k == KIND_ALLOC && out_tdata[1:0] == ST_OK)
        live_q.push_back('{addr: out_tdata[33:2], order: o});
    end
  end

  // Offer one item; hold tvalid across back-to-back transfers.
  task automatic send_item(input logic [1:0] kind, input logic [3:0] order,
                           input logic [31:0] addr);
    if ($urandom_range(99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < tx_idle_pct);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= {4'd0, addr, order};
    do @(posedge clk); while (!in_tready);
    kind_q.push_back(kind);
    order_q.push_back(order);
    items_sent++;
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  // Drop tvalid and wait until every result is back; every item yields one.
  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic configure(input logic [3:0] mo, input logic [9:0] res,
                           input logic [31:0] base);
    drain();
    write_reg(REG_MAX_ORDER, {28'd0, mo});
    write_reg(REG_RESERVED, {22'd0, res});
    write_reg(REG_BASE, base);
    cur_order = (mo > ORDER_LIMIT) ? ORDER_LIMIT : mo;
    cur_base = base;
  endtask

  // Random item: mostly allocate and release of real blocks, some noise.
  task automatic random_item();
    int unsigned pick, idx;
    live_block_t b;
    logic [3:0] ord;
    pick = $urandom_range(99);
    if (pick < 45) begin
      ord = ($urandom_range(9) == 0) ? 4'($urandom_range(15))
                                     : 4'($urandom_range(cur_order));
      send_item(KIND_ALLOC, ord, $urandom);
    end else if (pick < 82 && live_q.size() > 0) begin
      idx = $urandom_range(live_q.size() - 1);
      b = live_q[idx];
      live_q.delete(idx);
      // release the block at the order it was handed out with
      send_item(KIND_FREE, b.order, b.addr);
    end else if (pick < 92) begin
      ord = 4'($urandom_range(15));
      if ($urandom_range(1))
        send_item(KIND_FREE, ord, $urandom);
      else
        send_item(KIND_FREE, ord,
                  cur_base + ($urandom_range((2 << cur_order) - 1) << UNIT_SHIFT)
                  + $urandom_range(UNIT_BYTES - 1));
    end else if (pick < 96) begin
      send_item(KIND_INIT, 4'($urandom_range(15)), $urandom);
    end else begin
      send_item(KIND_NOP, 4'($urandom_range(15)), $urandom);
    end
  endtask

  initial begin
    int unsigned mo, res;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = '0;
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    cfg_paddr = '0;
    cfg_pwdata = '0;
    items_sent = 0;
    tx_idle_pct = 31;
    rx_idle_pct = 54;
    cur_order = 0;
    cur_base = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Before any init: allocate and free report not-initialized; no-op is fine.
    send_item(KIND_ALLOC, 4'd0, 32'd0);
    send_item(KIND_FREE, 4'd15, 32'hFFFF_FFFF);
    send_item(KIND_NOP, 4'd0, 32'd0);

    // Full pool at base zero.
    configure(4'd10, 10'd0, 32'd0);
    send_item(KIND_INIT, 4'd0, 32'd0);
    send_item(KIND_ALLOC, 4'd0, 32'd0);
    send_item(KIND_ALLOC, 4'd10, 32'd0);           // no block left that large
    send_item(KIND_ALLOC, 4'd11, 32'd0);           // order above pool
    send_item(KIND_ALLOC, 4'd15, 32'd0);
    send_item(KIND_FREE, 4'd0, 32'h0000_0000);     // merges back to the full pool
    send_item(KIND_ALLOC, 4'd10, 32'd0);
    send_item(KIND_FREE, 4'd3, 32'h0040_0000);     // outside the pool
    send_item(KIND_FREE, 4'd3, 32'h0000_5123);     // misaligned, rounded down
    send_item(KIND_FREE, 4'd0, 32'h0000_1000);     // lies in the block just freed
    send_item(KIND_NOP, 4'd15, 32'hFFFF_FFFF);

    // Order register saturates; reserve leaves one unit free; base near the top.
    configure(4'd15, 10'd1023, 32'hFFFF_F000);
    send_item(KIND_INIT, 4'd0, 32'd0);
    send_item(KIND_ALLOC, 4'd0, 32'd0);
    send_item(KIND_FREE, 4'd0, 32'hFFFF_F000);
    send_item(KIND_ALLOC, 4'd0, 32'd0);

    // Two-unit pool with one unit reserved; free wraps around the address space.
    configure(4'd1, 10'd1, 32'h8000_0000);
    send_item(KIND_INIT, 4'd0, 32'd0);
    send_item(KIND_ALLOC, 4'd1, 32'd0);
    send_item(KIND_ALLOC, 4'd0, 32'd0);
    send_item(KIND_ALLOC, 4'd0, 32'd0);
    send_item(KIND_FREE, 4'd0, 32'h8000_1000);
    send_item(KIND_FREE, 4'd0, 32'h7FFF_F000);

    // Random phases: small pools mostly, the largest once.
    for (int p = 0; p < 12; p++) begin
      if (p < 4) begin
        tx_idle_pct = 31; rx_idle_pct = 54;
      end else if (p < 8) begin
        tx_idle_pct = 54; rx_idle_pct = 31;
      end else begin
        tx_idle_pct = 0; rx_idle_pct = 0;
      end
      mo = (p == 11) ? 10 : $urandom_range(2, 7);
      res = ($urandom_range(4) == 0) ? $urandom_range(1023)
                                     : $urandom_range((1 << mo) + 2);
      configure(4'(mo), 10'(res), $urandom & 32'hFFFF_F000);
      send_item(KIND_INIT, 4'd0, 32'd0);
      for (int n = 0; n < ((p == 11) ? 100 : 160); n++)
        random_item();
    end

    drain();
    repeat (20) @(posedge clk);
    $display("Sent %0d items over 15 pool settings, checked %0d results,",
             items_sent, results_seen);
    $display("including a 400-cycle receiver hold-off and three idle patterns.");
    if (err_count == 0)
      $display("buddy_block_allocator_top_test: clean");
    else
      $display("buddy_block_allocator_top_test: errors");
    $finish;
  end

  initial begin
    #200_000_000;
    $display("buddy_block_allocator_top_test: errors");
    $finish;
  end
endmodule
